### design/tdl_pkg.sv
// ----------------------------------------------------------------------------
// tdl_pkg
// Shared types and constants of the token lexer: token kinds, character
// codes, the token record and the result queue geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package tdl_pkg;

  localparam int unsigned KIND_W = 5;
  localparam int unsigned OUT_W  = 16;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_LPAREN = 5'd0,
    KIND_RPAREN = 5'd1,
    KIND_LBRACE = 5'd2,
    KIND_RBRACE = 5'd3,
    KIND_COMMA  = 5'd4,
    KIND_SEMI   = 5'd5,
    KIND_COLON  = 5'd6,
    KIND_QUEST  = 5'd7,
    KIND_TILDE  = 5'd8,
    KIND_NUMBER = 5'd9,
    KIND_IDENT  = 5'd10,
    KIND_LT     = 5'd11,
    KIND_LE     = 5'd12,
    KIND_SHL    = 5'd13,
    KIND_SHLE   = 5'd14,
    KIND_GT     = 5'd15,
    KIND_GE     = 5'd16,
    KIND_SHR    = 5'd17,
    KIND_SHRE   = 5'd18,
    KIND_EOF    = 5'd19,
    KIND_ERR    = 5'd20
  } tok_kind_e;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UE     = 8'h45;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LE     = 8'h65;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  typedef struct packed {
    tok_kind_e        kind;
    logic [OUT_W-1:0] length;
    logic [OUT_W-1:0] line;
    logic [OUT_W-1:0] column;
    logic             last;
  } tdl_token_t;

  // tokens produced by one accepted byte, in order
  typedef struct packed {
    logic [1:0] cnt;
    tdl_token_t tok0;
    tdl_token_t tok1;
  } tdl_push_t;

endpackage

`default_nettype wire

### design/tdl_byte_if.sv
// ----------------------------------------------------------------------------
// tdl_byte_if
// Valid/ready channel carrying one source byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;

  modport source (output valid, output source_byte, input ready);
  modport sink (input valid, input source_byte, output ready);
endinterface

`default_nettype wire

### design/tdl_token_if.sv
// ----------------------------------------------------------------------------
// tdl_token_if
// Valid/ready channel carrying one token per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdl_token_if;
  import tdl_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] token_kind;
  logic [OUT_W-1:0]  token_length;
  logic [OUT_W-1:0]  token_line;
  logic [OUT_W-1:0]  token_column;
  logic              last_of_run;

  modport source (
    output valid, output token_kind, output token_length, output token_line,
    output token_column, output last_of_run, input ready
  );
  modport sink (
    input valid, input token_kind, input token_length, input token_line,
    input token_column, input last_of_run, output ready
  );
endinterface

`default_nettype wire

### design/tdl_scan.sv
// ----------------------------------------------------------------------------
// tdl_scan
// Scanner state machine: classifies the byte, holds scan state, pending
// length and position counters, and forms up to two tokens per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tdl_scan #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        source_byte_i,
  output tdl_pkg::tdl_push_t push_o
);
  import tdl_pkg::*;

  typedef enum logic [3:0] {
    S_START, S_NUM, S_NUM_DOT, S_EXP, S_EXP_SIGN,
    S_IDENT, S_LT, S_LTLT, S_GT, S_GTGT
  } state_e;

  typedef enum logic [2:0] {
    ACT_START, ACT_CONT, ACT_INCL, ACT_EXCL, ACT_EXPERR
  } act_e;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] ONE     = COUNT_BITS'(1);

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
    return (v == CNT_MAX) ? v : v + ONE;
  endfunction

  function automatic logic [OUT_W-1:0] sat16(input logic [COUNT_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (|w[31:16]) ? 16'hFFFF : w[15:0];
  endfunction

  state_e                state_q, state_d;
  logic [COUNT_BITS-1:0] plen_q, plen_d;
  logic [COUNT_BITS-1:0] line_q, col_q;

  // byte classes
  logic      is_nul, is_ws, is_nl, is_digit, is_alpha, is_ee, is_sign;
  logic      is_punct;
  tok_kind_e p_kind;

  always_comb begin
    is_nul   = (source_byte_i == CH_NUL);
    is_nl    = (source_byte_i == CH_NL);
    is_ws    = source_byte_i inside {CH_SPACE, CH_TAB, CH_CR, CH_NL};
    is_digit = source_byte_i inside {[CH_0:CH_9]};
    is_alpha = source_byte_i inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ], CH_US};
    is_ee    = source_byte_i inside {CH_LE, CH_UE};
    is_sign  = source_byte_i inside {CH_PLUS, CH_MINUS};
    is_punct = 1'b1;
    case (source_byte_i)
      CH_LPAREN: p_kind = KIND_LPAREN;
      CH_RPAREN: p_kind = KIND_RPAREN;
      CH_LBRACE: p_kind = KIND_LBRACE;
      CH_RBRACE: p_kind = KIND_RBRACE;
      CH_COMMA:  p_kind = KIND_COMMA;
      CH_SEMI:   p_kind = KIND_SEMI;
      CH_COLON:  p_kind = KIND_COLON;
      CH_QUEST:  p_kind = KIND_QUEST;
      CH_TILDE:  p_kind = KIND_TILDE;
      default: begin
        p_kind   = KIND_ERR;
        is_punct = 1'b0;
      end
    endcase
  end

  // scan from the start state
  logic                  s_tok_v, s_adv;
  tok_kind_e             s_kind;
  logic [OUT_W-1:0]      s_len;
  state_e                s_state;
  logic [COUNT_BITS-1:0] s_plen;

  always_comb begin
    s_tok_v = 1'b0;
    s_kind  = KIND_ERR;
    s_len   = OUT_W'(1);
    s_state = S_START;
    s_plen  = '0;
    s_adv   = 1'b1;
    if (is_nul) begin
      s_tok_v = 1'b1;
      s_kind  = KIND_EOF;
      s_len   = '0;
      s_adv   = 1'b0;
    end else if (is_ws) begin
      s_tok_v = 1'b0;
    end else if (is_punct) begin
      s_tok_v = 1'b1;
      s_kind  = p_kind;
    end else if (is_digit) begin
      s_state = S_NUM;
      s_plen  = ONE;
    end else if (is_alpha) begin
      s_state = S_IDENT;
      s_plen  = ONE;
    end else if (source_byte_i == CH_LT) begin
      s_state = S_LT;
      s_plen  = ONE;
    end else if (source_byte_i == CH_GT) begin
      s_state = S_GT;
      s_plen  = ONE;
    end else begin
      s_tok_v = 1'b1;
      s_kind  = KIND_ERR;
    end
  end

  // transition choice for the pending token
  act_e      act;
  tok_kind_e act_kind;
  state_e    cont_state;

  always_comb begin
    act        = ACT_START;
    act_kind   = KIND_ERR;
    cont_state = S_START;
    case (state_q)
      S_NUM, S_NUM_DOT: begin
        if (is_digit) begin
          act = ACT_CONT; cont_state = S_NUM;
        end else if (source_byte_i == CH_DOT && state_q == S_NUM) begin
          act = ACT_CONT; cont_state = S_NUM_DOT;
        end else if (is_ee) begin
          act = ACT_CONT; cont_state = S_EXP;
        end else begin
          act = ACT_EXCL; act_kind = KIND_NUMBER;
        end
      end
      S_EXP: begin
        if (is_sign) begin
          act = ACT_CONT; cont_state = S_EXP_SIGN;
        end else if (is_digit) begin
          act = ACT_CONT; cont_state = S_NUM;
        end else begin
          act = ACT_EXPERR;
        end
      end
      S_EXP_SIGN: begin
        if (is_digit) begin
          act = ACT_CONT; cont_state = S_NUM;
        end else begin
          act = ACT_EXPERR;
        end
      end
      S_IDENT: begin
        if (is_alpha || is_digit) begin
          act = ACT_CONT; cont_state = S_IDENT;
        end else begin
          act = ACT_EXCL; act_kind = KIND_IDENT;
        end
      end
      S_LT: begin
        if (source_byte_i == CH_EQ) begin
          act = ACT_INCL; act_kind = KIND_LE;
        end else if (source_byte_i == CH_LT) begin
          act = ACT_CONT; cont_state = S_LTLT;
        end else begin
          act = ACT_EXCL; act_kind = KIND_LT;
        end
      end
      S_LTLT: begin
        if (source_byte_i == CH_EQ) begin
          act = ACT_INCL; act_kind = KIND_SHLE;
        end else begin
          act = ACT_EXCL; act_kind = KIND_SHL;
        end
      end
      S_GT: begin
        if (source_byte_i == CH_EQ) begin
          act = ACT_INCL; act_kind = KIND_GE;
        end else if (source_byte_i == CH_GT) begin
          act = ACT_CONT; cont_state = S_GTGT;
        end else begin
          act = ACT_EXCL; act_kind = KIND_GT;
        end
      end
      S_GTGT: begin
        if (source_byte_i == CH_EQ) begin
          act = ACT_INCL; act_kind = KIND_SHRE;
        end else begin
          act = ACT_EXCL; act_kind = KIND_SHR;
        end
      end
      default: act = ACT_START;
    endcase
  end

  // resolve the action into tokens and next state
  logic                  use_start, f_v, f_at_tok, adv;
  tok_kind_e             f_kind;
  logic [OUT_W-1:0]      f_len;
  logic [COUNT_BITS-1:0] tok_col;
  tdl_token_t            f_tok, s_tok;
  logic                  s_v;

  always_comb begin
    use_start = 1'b0;
    f_v       = 1'b0;
    f_kind    = act_kind;
    f_len     = '0;
    f_at_tok  = 1'b0;
    state_d   = S_START;
    plen_d    = '0;
    adv       = 1'b1;
    case (act)
      ACT_CONT: begin
        state_d = cont_state;
        plen_d  = bump(plen_q);
      end
      ACT_INCL: begin
        f_v      = 1'b1;
        f_len    = sat16(bump(plen_q));
        f_at_tok = 1'b1;
      end
      ACT_EXCL: begin
        f_v       = 1'b1;
        f_len     = sat16(plen_q);
        f_at_tok  = 1'b1;
        use_start = 1'b1;
      end
      ACT_EXPERR: begin
        f_v    = 1'b1;
        f_kind = KIND_ERR;
        if (is_nul) begin
          use_start = 1'b1;
        end else begin
          f_len = OUT_W'(1);
        end
      end
      default: use_start = 1'b1;
    endcase
    if (use_start) begin
      state_d = s_state;
      plen_d  = s_plen;
      adv     = s_adv;
    end
  end

  assign tok_col = (col_q > plen_q) ? col_q - plen_q : ONE;
  assign s_v     = use_start && s_tok_v;

  always_comb begin
    f_tok.kind   = f_kind;
    f_tok.length = f_len;
    f_tok.line   = sat16(line_q);
    f_tok.column = f_at_tok ? sat16(tok_col) : sat16(col_q);
    f_tok.last   = !s_v;

    s_tok.kind   = s_kind;
    s_tok.length = s_len;
    s_tok.line   = sat16(line_q);
    s_tok.column = sat16(col_q);
    s_tok.last   = 1'b1;

    push_o.cnt  = accept_i ? 2'({1'b0, f_v} + {1'b0, s_v}) : 2'd0;
    push_o.tok0 = f_v ? f_tok : s_tok;
    push_o.tok1 = s_tok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_START;
      plen_q  <= '0;
      line_q  <= ONE;
      col_q   <= ONE;
    end else if (accept_i) begin
      state_q <= state_d;
      plen_q  <= plen_d;
      if (adv) begin
        if (is_nl) begin
          line_q <= bump(line_q);
          col_q  <= ONE;
        end else begin
          col_q <= bump(col_q);
        end
      end
    end
  end

`ifndef SYNTH
  // no pending token outside a token state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_START |-> plen_q == '0)
    else $error("pending length held in start state");

  // counters never leave their 1-based range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0 && col_q != '0)
    else $error("position counter reached zero");

  // end of input always closes the run with an eof token
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && is_nul |->
      (push_o.cnt == 2'd1 && push_o.tok0.kind == KIND_EOF) ||
      (push_o.cnt == 2'd2 && push_o.tok1.kind == KIND_EOF))
    else $error("nul byte without eof token");
`endif

endmodule

`default_nettype wire

### design/tdl_fifo.sv
// ----------------------------------------------------------------------------
// tdl_fifo
// Result queue: takes up to two tokens per cycle, hands out one per cycle while the sink is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module tdl_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tdl_pkg::tdl_push_t  push_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tdl_pkg::tdl_token_t out_tok_o
);
  import tdl_pkg::*;

  tdl_token_t       mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             pop;

  assign out_valid_o = (count_q != '0);
  assign out_tok_o   = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  // room for a two-token run whatever the sink does
  assign in_ready_o  = (count_q <= CNT_W'(FIFO_DEPTH - 2));

  assign wr_ptr_d = wr_ptr_q + PTR_W'(push_i.cnt);
  assign rd_ptr_d = rd_ptr_q + PTR_W'(pop);
  assign count_d  = count_q + CNT_W'(push_i.cnt) - CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.tok0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_q + PTR_W'(1)] <= push_i.tok1;
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |->
      (32'(count_q) + 32'(push_i.cnt) - 32'(pop)) <= FIFO_DEPTH)
    else $error("push without room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 && push_i.cnt != 2'd0 |=> out_valid_o)
    else $error("pushed item not presented");
`endif

endmodule

`default_nettype wire

### design/table_driven_token_lexer_top.sv
// ----------------------------------------------------------------------------
// table_driven_token_lexer_top
// Table-driven token lexer: one source byte in per item, tokens out with
// kind, length, start line and start column.
//
//   channel  dir  modport             payload
//   src_i    in   tdl_byte_if.sink    source_byte
//   tok_o    out  tdl_token_if.source token_kind, token_length, token_line,
//                                     token_column, last_of_run
//
// a byte is scanned in the cycle it is accepted; its tokens are registered in
// the four-entry result queue and presented from there in order
// one byte per cycle while the result queue has room; a byte that yields two
// tokens is drained through the single output port of the queue
// src_i.ready depends only on queue occupancy (at most two entries held)
// reset returns to the start state with line and column at 1
// ----------------------------------------------------------------------------
`default_nettype none

module table_driven_token_lexer_top #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  tdl_byte_if.sink           src_i,
  tdl_token_if.source        tok_o
);
  import tdl_pkg::*;

  logic       fifo_ready;
  logic       accept;
  tdl_push_t  push;
  tdl_token_t out_tok;

  assign src_i.ready = fifo_ready;
  assign accept      = src_i.valid && fifo_ready;

  tdl_scan #(
    .COUNT_BITS (COUNT_BITS)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .source_byte_i (src_i.source_byte),
    .push_o        (push)
  );

  tdl_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_ready_o  (fifo_ready),
    .out_valid_o (tok_o.valid),
    .out_ready_i (tok_o.ready),
    .out_tok_o   (out_tok)
  );

  assign tok_o.token_kind   = out_tok.kind;
  assign tok_o.token_length = out_tok.length;
  assign tok_o.token_line   = out_tok.line;
  assign tok_o.token_column = out_tok.column;
  assign tok_o.last_of_run  = out_tok.last;

endmodule

`default_nettype wire
